// ----- rtl/core/cht_pkg.sv -----
// Shared types, constants and width helpers for the hazard table hit test.
package cht_pkg;

  localparam int unsigned DEF_MAX_SLOTS = 8;

  // Field widths of the transaction payloads
  localparam int unsigned KIND_W = 2;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned SIZE_W = 15;
  localparam int unsigned RAD_W  = 14;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned CFG_W  = 4;

  // Datapath widths
  localparam int unsigned DIFF_W = POS_W + 1;        // coordinate difference
  localparam int unsigned SQ_W   = 2 * POS_W + 1;    // square of a difference
  localparam int unsigned DIST_W = SQ_W + 1;         // sum of two squares
  localparam int unsigned LIM_W  = RAD_W + 1;        // sum of two radii
  localparam int unsigned LSQ_W  = 2 * LIM_W;        // squared limit

  // Cycles from the last slot issue until the hit flags settle
  localparam int unsigned DRAIN_CYCLES = 3;
  localparam int unsigned DRAIN_W      = $clog2(DRAIN_CYCLES);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [SLOT_W-1:0]        slot;
    logic [KIND_W-1:0]        kind;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [SIZE_W-1:0]        size_w;
    logic [SIZE_W-1:0]        size_h;
    logic [RAD_W-1:0]         radius;
    logic                     circular;
    logic                     active;
  } cht_in_t;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] hit_kind;
  } cht_out_t;

  // One stored table entry (active flags live in flops beside the memory)
  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [SIZE_W-1:0]        w;
    logic [SIZE_W-1:0]        h;
    logic [RAD_W-1:0]         r;
    logic                     circ;
  } cht_slot_t;

  typedef struct packed {
    logic load;   // capture the incoming transaction, clear the result
    logic write;  // store the captured slot
    logic issue;  // read one slot into the hit pipeline
  } cht_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_REPLY
  } cht_state_e;

  function automatic int unsigned idx_width(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int unsigned cnt_width(int unsigned n);
    return $clog2(n + 1);
  endfunction

endpackage

// ----- rtl/core/cht_ctrl.sv -----
// Controller state machine: sequences writes, slot scans, drain and reply.
module cht_ctrl import cht_pkg::*; #(
  parameter int unsigned MaxSlots = DEF_MAX_SLOTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             func_i,
  input  logic [cnt_width(MaxSlots)-1:0]   scan_n_i,
  output cht_cmd_t                         cmd_o,
  output logic [idx_width(MaxSlots)-1:0]   idx_o,
  output logic                             done_o
);

  localparam int unsigned CntW = cnt_width(MaxSlots);
  localparam int unsigned IdxW = idx_width(MaxSlots);

  cht_state_e          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DRAIN_W-1:0]  drn_q, drn_d;
  logic [CntW-1:0]     cnt_inc;

  assign cnt_inc = cnt_q + CntW'(1);
  assign idx_o   = cnt_q[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      drn_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drn_q   <= drn_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    drn_d   = drn_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE, ST_REPLY: begin
        busy   = 1'b0;
        done_o = (state_q == ST_REPLY);
        state_d = ST_IDLE;
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          drn_d      = '0;
          if (func_i == FUNC_WRITE) begin
            state_d = ST_WRITE;
          end else if (scan_n_i == '0) begin
            state_d = ST_DRAIN;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = ST_REPLY;
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        cnt_d       = cnt_inc;
        if (cnt_inc == scan_n_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // hold until the last issued slot has passed the compare stage
        drn_d = drn_q + DRAIN_W'(1);
        if (drn_q == DRAIN_W'(DRAIN_CYCLES - 1)) begin
          state_d = ST_REPLY;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/cht_dpath.sv -----
// Datapath: slot memory, active flags, count register and the hit pipeline.
module cht_dpath import cht_pkg::*; #(
  parameter int unsigned MaxSlots = DEF_MAX_SLOTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cht_in_t                          item_i,
  input  cht_cmd_t                         cmd_i,
  input  logic [idx_width(MaxSlots)-1:0]   idx_i,
  input  logic                             cfg_we_i,
  input  logic [CFG_W-1:0]                 cfg_data_i,
  output logic [cnt_width(MaxSlots)-1:0]   scan_n_o,
  output cht_out_t                         result_o
);

  localparam int unsigned CntW = cnt_width(MaxSlots);
  localparam int unsigned IdxW = idx_width(MaxSlots);

  cht_in_t             item_q;
  logic [CFG_W-1:0]    count_q;
  cht_slot_t           mem [MaxSlots];
  logic [MaxSlots-1:0] act_q;
  cht_slot_t           rd_q;

  logic [6:0]          slot_ext;
  logic                slot_ok;
  logic [IdxW-1:0]     wr_addr;
  cht_slot_t           wr_entry;
  logic [7:0]          cnt_ext;
  logic [7:0]          cnt_sat;

  // pipeline stage registers
  logic                       v1_q, v2_q, v3_q;
  logic [KIND_W-1:0]          k2_q, k3_q;
  logic signed [DIFF_W-1:0]   dx_q, dy_q;
  logic [LIM_W-1:0]           lim_q;
  logic [SQ_W-1:0]            sqx_q, sqy_q;
  logic [LSQ_W-1:0]           lsq_q;
  logic                       found_q;
  logic [KIND_W-1:0]          kind_q;

  logic signed [DIFF_W-1:0]   qx, qy, lo_x, lo_y, hi_x, hi_y, cx, cy;
  logic signed [DIFF_W-1:0]   dx_d, dy_d;
  logic [LIM_W-1:0]           lim_d;
  logic signed [2*DIFF_W-1:0] px, py;
  logic [LSQ_W-1:0]           lsq_d;
  logic [DIST_W-1:0]          dist_sq;
  logic                       hit3;

  // count register, saturated to the table depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  assign cnt_ext  = 8'(count_q);
  assign cnt_sat  = (cnt_ext > 8'(MaxSlots)) ? 8'(MaxSlots) : cnt_ext;
  assign scan_n_o = cnt_sat[CntW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // table write
  assign slot_ext = 7'(item_q.slot);
  assign slot_ok  = slot_ext < 7'(MaxSlots);
  assign wr_addr  = slot_ext[IdxW-1:0];

  always_comb begin
    wr_entry.kind = item_q.kind;
    wr_entry.x    = item_q.pos_x;
    wr_entry.y    = item_q.pos_y;
    wr_entry.w    = item_q.size_w;
    wr_entry.h    = item_q.size_h;
    wr_entry.r    = item_q.radius;
    wr_entry.circ = item_q.circular;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && slot_ok) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_q <= mem[idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
    end else if (cmd_i.write && slot_ok) begin
      act_q[wr_addr] <= item_q.active;
    end
  end

  // stage 2: offsets from the slot to the query centre, and the radius limit
  assign qx   = {item_q.pos_x[POS_W-1], item_q.pos_x};
  assign qy   = {item_q.pos_y[POS_W-1], item_q.pos_y};
  assign lo_x = {rd_q.x[POS_W-1], rd_q.x};
  assign lo_y = {rd_q.y[POS_W-1], rd_q.y};
  assign hi_x = lo_x + $signed({2'b00, rd_q.w});
  assign hi_y = lo_y + $signed({2'b00, rd_q.h});
  assign cx   = (qx < lo_x) ? lo_x : ((qx > hi_x) ? hi_x : qx);
  assign cy   = (qy < lo_y) ? lo_y : ((qy > hi_y) ? hi_y : qy);

  always_comb begin
    if (rd_q.circ) begin
      dx_d  = qx - lo_x;
      dy_d  = qy - lo_y;
      lim_d = {1'b0, rd_q.r} + {1'b0, item_q.radius};
    end else begin
      dx_d  = qx - cx;
      dy_d  = qy - cy;
      lim_d = {1'b0, item_q.radius};
    end
  end

  // stage 3: squares
  assign px    = dx_q * dx_q;
  assign py    = dy_q * dy_q;
  assign lsq_d = lim_q * lim_q;

  // stage 4: compare
  assign dist_sq = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign hit3    = v3_q && (dist_sq < DIST_W'(lsq_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue && act_q[idx_i];
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    lim_q <= lim_d;
    k2_q  <= rd_q.kind;
    sqx_q <= px[SQ_W-1:0];
    sqy_q <= py[SQ_W-1:0];
    lsq_q <= lsq_d;
    k3_q  <= k2_q;
  end

  // keep only the first hit in scan order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      kind_q  <= '0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
      kind_q  <= '0;
    end else if (hit3 && !found_q) begin
      found_q <= 1'b1;
      kind_q  <= k3_q;
    end
  end

  assign result_o.hit      = found_q;
  assign result_o.hit_kind = kind_q;

endmodule

// ----- rtl/core/circle_hazard_table_hit_test_core.sv -----
// Top level of the hazard table hit test: controller plus datapath.
//
// Usage: present a transaction on cmd_i and raise start; it is taken at a
// rising edge with start high and busy low. func selects a slot write or a
// circle query. Each transaction gives exactly one result on result_o,
// marked by done_o for a single cycle; the receiver cannot stall it.
// A write result is hit = 0, hit_kind = 0.
// A write passes through the write state and raises done_o in the reply
// state. A query scans N = min(hazard_count, MaxSlots) slots, one slot
// memory read per cycle, then drains the multiply/compare pipeline, and
// done_o comes in the reply state after the drain. The next transaction
// is taken during the done_o cycle.
// hazard_count is written over cfg_valid_i/cfg_data_i; cfg_ready_o is
// always high. Write it only while no transaction is in flight.
// Reset clears the count, all active flags and the controller; the slot
// memory itself is not cleared.
module circle_hazard_table_hit_test_core import cht_pkg::*; #(
  parameter int unsigned MaxSlots = DEF_MAX_SLOTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cht_in_t          cmd_i,
  output logic             done_o,
  output cht_out_t         result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  cht_cmd_t                         cmd;
  logic [idx_width(MaxSlots)-1:0]   idx;
  logic [cnt_width(MaxSlots)-1:0]   scan_n;

  assign cfg_ready_o = 1'b1;

  cht_ctrl #(
    .MaxSlots(MaxSlots)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .func_i   (cmd_i.func),
    .scan_n_i (scan_n),
    .cmd_o    (cmd),
    .idx_o    (idx),
    .done_o   (done_o)
  );

  cht_dpath #(
    .MaxSlots(MaxSlots)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (cmd_i),
    .cmd_i      (cmd),
    .idx_i      (idx),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .scan_n_o   (scan_n),
    .result_o   (result_o)
  );

endmodule

// ----- verif/circle_hazard_table_hit_test_core_tb.sv -----
// Self-checking testbench for the hazard table hit test core.
`timescale 1ns / 100ps

module circle_hazard_table_hit_test_core_tb import cht_pkg::*;;

  localparam int unsigned N_SLOTS       = DEF_MAX_SLOTS;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT   = 400;
  localparam int unsigned RANDOM_ITEMS  = 1900;

  localparam logic [KIND_W-1:0] KIND_FLAMES = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WALL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PIT    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OTHER  = 2'd3;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  cht_in_t          cmd;
  logic             done;
  cht_out_t         result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  // Shadow copy of the hazard table and the count register
  logic [KIND_W-1:0]       tbl_kind   [N_SLOTS];
  logic signed [POS_W-1:0] tbl_x      [N_SLOTS];
  logic signed [POS_W-1:0] tbl_y      [N_SLOTS];
  logic [SIZE_W-1:0]       tbl_w      [N_SLOTS];
  logic [SIZE_W-1:0]       tbl_h      [N_SLOTS];
  logic [RAD_W-1:0]        tbl_r      [N_SLOTS];
  bit                      tbl_circle [N_SLOTS];
  bit                      tbl_active [N_SLOTS];
  logic [CFG_W-1:0]        model_count = '0;

  cht_out_t    expected_hits[$];
  int          mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  bit          gaps_on        = 1'b1;
  int unsigned burst_left     = 0;
  int unsigned phase_count [12] = '{8, 0, 15, 3, 8, 1, 12, 5, 8, 7, 2, 9};

  circle_hazard_table_hit_test_core #(
    .MaxSlots(N_SLOTS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd),
    .done_o     (done),
    .result_o   (result),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint clamp_span(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Apply one transaction to the shadow table and return the result it should produce
  function automatic cht_out_t predict_hit(cht_in_t it);
    cht_out_t    res;
    int unsigned n;
    longint      qx, qy, qr, dx, dy, lim;
    res = '0;
    if (it.func == FUNC_WRITE) begin
      if (it.slot < N_SLOTS) begin
        tbl_kind[it.slot]   = it.kind;
        tbl_x[it.slot]      = it.pos_x;
        tbl_y[it.slot]      = it.pos_y;
        tbl_w[it.slot]      = it.size_w;
        tbl_h[it.slot]      = it.size_h;
        tbl_r[it.slot]      = it.radius;
        tbl_circle[it.slot] = it.circular;
        tbl_active[it.slot] = it.active;
      end
    end else begin
      n  = (model_count > N_SLOTS) ? N_SLOTS : model_count;
      qx = longint'(it.pos_x);
      qy = longint'(it.pos_y);
      qr = longint'(it.radius);
      for (int unsigned i = 0; i < n; i++) begin
        if (tbl_active[i] && !res.hit) begin
          if (tbl_circle[i]) begin
            dx  = qx - longint'(tbl_x[i]);
            dy  = qy - longint'(tbl_y[i]);
            lim = longint'(tbl_r[i]) + qr;
          end else begin
            dx  = qx - clamp_span(qx, longint'(tbl_x[i]),
                                  longint'(tbl_x[i]) + longint'(tbl_w[i]));
            dy  = qy - clamp_span(qy, longint'(tbl_y[i]),
                                  longint'(tbl_y[i]) + longint'(tbl_h[i]));
            lim = qr;
          end
          if (dx * dx + dy * dy < lim * lim) begin
            res.hit      = 1'b1;
            res.hit_kind = tbl_kind[i];
          end
        end
      end
    end
    return res;
  endfunction

  function automatic cht_in_t make_write(logic [SLOT_W-1:0] slot, logic [KIND_W-1:0] kind,
                                         int x, int y, int w, int h, int r,
                                         bit circ, bit act);
    cht_in_t it;
    it.func     = FUNC_WRITE;
    it.slot     = slot;
    it.kind     = kind;
    it.pos_x    = POS_W'(x);
    it.pos_y    = POS_W'(y);
    it.size_w   = SIZE_W'(w);
    it.size_h   = SIZE_W'(h);
    it.radius   = RAD_W'(r);
    it.circular = circ;
    it.active   = act;
    return it;
  endfunction

  // Fields a query ignores carry random values
  function automatic cht_in_t make_query(int x, int y, int r);
    cht_in_t it;
    it.func     = FUNC_QUERY;
    it.slot     = SLOT_W'($urandom);
    it.kind     = KIND_W'($urandom);
    it.pos_x    = POS_W'(x);
    it.pos_y    = POS_W'(y);
    it.size_w   = SIZE_W'($urandom);
    it.size_h   = SIZE_W'($urandom);
    it.radius   = RAD_W'(r);
    it.circular = 1'($urandom);
    it.active   = 1'($urandom);
    return it;
  endfunction

  function automatic int jitter_pos(int c);
    return c + int'($urandom_range(0, 6000)) - 3000;
  endfunction

  // Hazards and queries clustered around one point so that hits are common
  function automatic cht_in_t rand_scene_item(int cx, int cy);
    if ($urandom_range(0, 9) < 3)
      return make_write(SLOT_W'($urandom_range(0, N_SLOTS - 1)), KIND_W'($urandom),
                        jitter_pos(cx), jitter_pos(cy),
                        int'($urandom_range(0, 3071)), int'($urandom_range(0, 3071)),
                        int'($urandom_range(0, 1023)), 1'($urandom),
                        $urandom_range(0, 6) != 0);
    return make_query(jitter_pos(cx), jitter_pos(cy), int'($urandom_range(0, 1535)));
  endfunction

  function automatic cht_in_t rand_wide_item();
    cht_in_t it;
    it.func     = 1'($urandom);
    it.slot     = SLOT_W'($urandom);
    it.kind     = KIND_W'($urandom);
    it.pos_x    = POS_W'($urandom);
    it.pos_y    = POS_W'($urandom);
    it.size_w   = SIZE_W'($urandom);
    it.size_h   = SIZE_W'($urandom);
    it.radius   = RAD_W'($urandom);
    it.circular = 1'($urandom);
    it.active   = 1'($urandom);
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [3:0] got, logic [3:0] want);
    $display("MISMATCH at %0t ns: %s = %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Drive one transaction; called and returns at a falling edge
  task automatic send_item(cht_in_t it);
    if (burst_left == 0) begin
      if (gaps_on) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    start <= 1'b1;
    cmd   <= it;
    do @(posedge clk_i); while (busy);
    expected_hits = {expected_hits, predict_hit(it)};
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_hits.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_hazard_count(logic [CFG_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    model_count = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Count register comes out of reset at zero and every slot inactive
  task automatic test_reset_state();
    send_item(make_query(0, 0, 100));
    set_hazard_count(4'd8);
    send_item(make_query(0, 0, 16383));
  endtask

  task automatic test_circle_hits();
    send_item(make_write(3'd0, KIND_WALL, 0, 0, 0, 0, 16, 1'b1, 1'b1));
    send_item(make_query(32, 0, 16));   // touching only, not a hit
    send_item(make_query(31, 0, 16));
    send_item(make_query(0, 0, 0));
    send_item(make_write(3'd0, KIND_WALL, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    send_item(make_query(0, 0, 0));     // zero radius on both sides
  endtask

  task automatic test_rect_hits();
    send_item(make_write(3'd1, KIND_PIT, 160, 160, 80, 80, 0, 1'b0, 1'b1));
    send_item(make_query(200, 200, 0)); // inside, but zero radius
    send_item(make_query(200, 200, 1));
    send_item(make_query(150, 200, 10));
    send_item(make_query(150, 200, 11));
    send_item(make_query(150, 150, 15));
  endtask

  task automatic test_scan_order();
    send_item(make_write(3'd2, KIND_OTHER, 200, 200, 0, 0, 50, 1'b1, 1'b1));
    send_item(make_query(200, 200, 5));
    send_item(make_write(3'd1, KIND_PIT, 160, 160, 80, 80, 0, 1'b0, 1'b0));
    send_item(make_query(200, 200, 5));
  endtask

  task automatic test_hazard_count();
    set_hazard_count(4'd2);
    send_item(make_query(200, 200, 5));
    set_hazard_count(4'd15);
    send_item(make_query(200, 200, 5));
    set_hazard_count(4'd3);
    send_item(make_query(200, 200, 5));
  endtask

  task automatic test_field_extremes();
    set_hazard_count(4'd8);
    send_item(make_write(3'd7, KIND_FLAMES, -32768, -32768, 0, 0, 16383, 1'b1, 1'b1));
    send_item(make_write(3'd6, KIND_FLAMES, 32767, 32767, 32767, 32767, 16383,
                         1'b0, 1'b1));
    send_item(make_query(32767, -32768, 16383));
    send_item(make_query(-32768, 32767, 16383));
  endtask

  task automatic test_random_traffic();
    int          cx, cy;
    int unsigned per_phase;
    per_phase = RANDOM_ITEMS / $size(phase_count);
    foreach (phase_count[p]) begin
      set_hazard_count(CFG_W'(phase_count[p]));
      gaps_on = ($urandom_range(0, 3) != 0);
      cx = int'($urandom_range(0, 40000)) - 20000;
      cy = int'($urandom_range(0, 40000)) - 20000;
      repeat (per_phase) begin
        if ($urandom_range(0, 9) == 0)
          send_item(rand_wide_item());
        else
          send_item(rand_scene_item(cx, cy));
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    cht_out_t want;
    if (rst_ni && done) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("result with nothing pending, hit", 4'(result.hit), 4'd0);
      end else begin
        want = expected_hits.pop_front();
        if (result.hit !== want.hit)
          report_mismatch("hit", 4'(result.hit), 4'(want.hit));
        if (result.hit_kind !== want.hit_kind)
          report_mismatch("hit_kind", 4'(result.hit_kind), 4'(want.hit_kind));
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    clk_i     = 1'b0;
    rst_ni    = 1'b0;
    start     = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_circle_hits();
    test_rect_hits();
    test_scan_order();
    test_hazard_count();
    test_field_extremes();
    test_random_traffic();

    wait_idle();
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/cht_pkg.sv
rtl/core/cht_ctrl.sv
rtl/core/cht_dpath.sv
rtl/core/circle_hazard_table_hit_test_core.sv
verif/circle_hazard_table_hit_test_core_tb.sv
